// ===== rtl/rtufbc_pkg.sv =====
`timescale 1ns / 1ps

package rtufbc_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 256;

  localparam logic [15:0] CRC_START_RST = 16'hFFFF;
  localparam logic [15:0] CRC_POLY_RST  = 16'hA001;

  // Configuration register indexes.
  localparam logic [1:0] CFG_IDX_MODE  = 2'd0;
  localparam logic [1:0] CFG_IDX_START = 2'd1;
  localparam logic [1:0] CFG_IDX_POLY  = 2'd2;

  localparam logic MODE_BUILD = 1'b0;
  localparam logic MODE_CHECK = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_FRAME  = 2'd0;
  localparam logic [1:0] KIND_PDU    = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Step of the current input item.
  typedef enum logic [2:0] {
    PH_SA,
    PH_FC,
    PH_DATA,
    PH_CRCL,
    PH_CRCH,
    PH_CHK,
    PH_STAT
  } phase_t;

  // One byte through the reflected CRC, eight bit steps.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                           input logic [7:0]  data,
                                           input logic [15:0] poly);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ poly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/rtu_frame_builder_checker.sv =====
`timescale 1ns / 1ps

// Modbus RTU framer (mode 0) and deframer/checker (mode 1) with a reflected CRC-16, one byte
// per input transaction. An input transaction is held in a one-entry input register and expanded
// into its results, one result per cycle unless stalled, into a registered output stage, so a new
// transaction is taken in the same cycle the previous one hands over its last result. A byte that
// yields at most one result (a check-mode byte that is not last, or a mid-PDU build-mode byte)
// takes one step; a check-mode last byte takes two; a build-mode first or last byte takes three,
// and a build-mode byte that is both first and last takes five. The rate is set by the single
// byte-wide CRC update per cycle and the single output register. In build mode the first byte
// prepends slave address and function code, and the last byte appends the CRC low byte first.
// In check mode PDU bytes come out two bytes late so the CRC bytes are dropped, and the last
// byte yields a status result. Configuration must be written only while the block is idle.
module rtu_frame_builder_checker #(
  parameter int MAX_FRAME_BYTES = rtufbc_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // data_byte[7:0], slave_address[15:8], function_code[23:16]
  input  logic        in_tuser,   // first_byte
  input  logic        in_tlast,   // last_byte
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // out_byte[7:0], crc_good[8], payload_present[9],
                                  // found_slave[17:10], found_function[25:18], zero[31:26]
  output logic [1:0]  out_tuser,  // item_kind
  output logic        out_tlast   // end_of_run
);

  localparam int CW = $clog2(MAX_FRAME_BYTES + 1);

  // Configuration registers.
  logic        mode_r;
  logic [15:0] start_r;
  logic [15:0] poly_r;

  // Frame state.
  logic [15:0]   crc_r, crc_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    older_r, older_nxt;
  logic [7:0]    newer_r, newer_nxt;
  logic [7:0]    cap_sl_r, cap_sl_nxt;
  logic [7:0]    cap_fn_r, cap_fn_nxt;

  // Input holding stage.
  logic                 hold_v_r;
  logic [7:0]           hold_data_r;
  logic [7:0]           hold_sa_r;
  logic [7:0]           hold_fc_r;
  logic                 hold_first_r;
  logic                 hold_last_r;
  rtufbc_pkg::phase_t   phase_r, phase_nxt, phase_start;
  logic                 phase_end;

  // Output register.
  logic        out_v_r;
  logic [31:0] out_data_r;
  logic [1:0]  out_kind_r;
  logic        out_last_r;

  logic        adv;
  logic        step;
  logic        hold_done;
  logic        in_acc;

  // Result of the current step.
  logic        emit_c;
  logic [7:0]  ob_c;
  logic [1:0]  kind_c;
  logic        good_c;
  logic        pay_c;
  logic [7:0]  sl_c;
  logic [7:0]  fn_c;
  logic        end_c;

  // Frame state as seen by this step, after a rearm on a first byte.
  logic          rearm_now;
  logic [15:0]   crc_base;
  logic [CW-1:0] cnt_base;
  logic [CW-1:0] cnt_up;
  logic [7:0]    older_base;
  logic [7:0]    newer_base;

  assign adv       = !out_v_r || out_tready;
  assign step      = hold_v_r && adv;
  assign hold_done = step && phase_end;
  assign in_tready = !hold_v_r || hold_done;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    if (mode_r == rtufbc_pkg::MODE_CHECK) begin
      phase_start = rtufbc_pkg::PH_CHK;
    end else if (in_tuser) begin
      phase_start = rtufbc_pkg::PH_SA;
    end else begin
      phase_start = rtufbc_pkg::PH_DATA;
    end
  end

  // Next step of the held transaction.
  always_comb begin
    phase_nxt = phase_r;
    phase_end = 1'b0;
    case (phase_r)
      rtufbc_pkg::PH_SA:   phase_nxt = rtufbc_pkg::PH_FC;
      rtufbc_pkg::PH_FC:   phase_nxt = rtufbc_pkg::PH_DATA;
      rtufbc_pkg::PH_DATA: begin
        if (hold_last_r) begin
          phase_nxt = rtufbc_pkg::PH_CRCL;
        end else begin
          phase_end = 1'b1;
        end
      end
      rtufbc_pkg::PH_CRCL: phase_nxt = rtufbc_pkg::PH_CRCH;
      rtufbc_pkg::PH_CRCH: phase_end = 1'b1;
      rtufbc_pkg::PH_CHK: begin
        if (hold_last_r) begin
          phase_nxt = rtufbc_pkg::PH_STAT;
        end else begin
          phase_end = 1'b1;
        end
      end
      rtufbc_pkg::PH_STAT: phase_end = 1'b1;
      default:             phase_end = 1'b1;
    endcase
  end

  assign rearm_now  = hold_first_r &&
                      (phase_r inside {rtufbc_pkg::PH_SA, rtufbc_pkg::PH_CHK});
  assign crc_base   = rearm_now ? start_r : crc_r;
  assign cnt_base   = rearm_now ? '0 : cnt_r;
  assign older_base = rearm_now ? 8'h00 : older_r;
  assign newer_base = rearm_now ? 8'h00 : newer_r;
  assign cnt_up     = (cnt_base < CW'(MAX_FRAME_BYTES)) ? cnt_base + CW'(1) : cnt_base;

  // Result and state update of the current step.
  always_comb begin
    crc_nxt    = crc_base;
    cnt_nxt    = cnt_base;
    older_nxt  = older_base;
    newer_nxt  = newer_base;
    cap_sl_nxt = cap_sl_r;
    cap_fn_nxt = cap_fn_r;
    emit_c     = 1'b0;
    ob_c       = 8'h00;
    kind_c     = rtufbc_pkg::KIND_FRAME;
    good_c     = 1'b0;
    pay_c      = 1'b0;
    sl_c       = 8'h00;
    fn_c       = 8'h00;
    end_c      = 1'b0;
    case (phase_r)
      rtufbc_pkg::PH_SA: begin
        cap_sl_nxt = hold_sa_r;
        cap_fn_nxt = hold_fc_r;
        crc_nxt    = rtufbc_pkg::crc_feed(crc_base, hold_sa_r, poly_r);
        cnt_nxt    = cnt_up;
        emit_c     = 1'b1;
        ob_c       = hold_sa_r;
      end
      rtufbc_pkg::PH_FC: begin
        crc_nxt = rtufbc_pkg::crc_feed(crc_base, hold_fc_r, poly_r);
        cnt_nxt = cnt_up;
        emit_c  = 1'b1;
        ob_c    = hold_fc_r;
      end
      rtufbc_pkg::PH_DATA: begin
        crc_nxt = rtufbc_pkg::crc_feed(crc_base, hold_data_r, poly_r);
        cnt_nxt = cnt_up;
        emit_c  = 1'b1;
        ob_c    = hold_data_r;
      end
      rtufbc_pkg::PH_CRCL: begin
        emit_c = 1'b1;
        ob_c   = crc_r[7:0];
      end
      rtufbc_pkg::PH_CRCH: begin
        emit_c    = 1'b1;
        ob_c      = crc_r[15:8];
        end_c     = 1'b1;
        crc_nxt   = start_r;
        cnt_nxt   = '0;
        older_nxt = 8'h00;
        newer_nxt = 8'h00;
      end
      rtufbc_pkg::PH_CHK: begin
        crc_nxt = rtufbc_pkg::crc_feed(crc_base, hold_data_r, poly_r);
        if (cnt_base == CW'(0)) begin
          cap_sl_nxt = hold_data_r;
        end else if (cnt_base == CW'(1)) begin
          cap_fn_nxt = hold_data_r;
        end
        // The delay line keeps the last two bytes back, so the CRC bytes never leave.
        emit_c    = (cnt_base >= CW'(4));
        ob_c      = older_base;
        kind_c    = rtufbc_pkg::KIND_PDU;
        older_nxt = newer_base;
        newer_nxt = hold_data_r;
        cnt_nxt   = cnt_up;
      end
      rtufbc_pkg::PH_STAT: begin
        emit_c    = 1'b1;
        kind_c    = rtufbc_pkg::KIND_STATUS;
        good_c    = (crc_r == 16'h0000);
        pay_c     = (cnt_r > CW'(4));
        sl_c      = pay_c ? cap_sl_r : 8'h00;
        fn_c      = pay_c ? cap_fn_r : 8'h00;
        end_c     = 1'b1;
        crc_nxt   = start_r;
        cnt_nxt   = '0;
        older_nxt = 8'h00;
        newer_nxt = 8'h00;
      end
      default: begin
        emit_c = 1'b0;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= rtufbc_pkg::MODE_BUILD;
      start_r <= rtufbc_pkg::CRC_START_RST;
      poly_r  <= rtufbc_pkg::CRC_POLY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rtufbc_pkg::CFG_IDX_MODE:  mode_r  <= cfg_wdata[0];
        rtufbc_pkg::CFG_IDX_START: start_r <= cfg_wdata;
        rtufbc_pkg::CFG_IDX_POLY:  poly_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Frame state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r    <= rtufbc_pkg::CRC_START_RST;
      cnt_r    <= '0;
      older_r  <= 8'h00;
      newer_r  <= 8'h00;
      cap_sl_r <= 8'h00;
      cap_fn_r <= 8'h00;
    end else if (step) begin
      crc_r    <= crc_nxt;
      cnt_r    <= cnt_nxt;
      older_r  <= older_nxt;
      newer_r  <= newer_nxt;
      cap_sl_r <= cap_sl_nxt;
      cap_fn_r <= cap_fn_nxt;
    end
  end

  // Input holding stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      phase_r  <= rtufbc_pkg::PH_DATA;
    end else if (in_acc) begin
      hold_v_r <= 1'b1;
      phase_r  <= phase_start;
    end else if (hold_done) begin
      hold_v_r <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      hold_data_r  <= in_tdata[7:0];
      hold_sa_r    <= in_tdata[15:8];
      hold_fc_r    <= in_tdata[23:16];
      hold_first_r <= in_tuser;
      hold_last_r  <= in_tlast;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= hold_v_r && emit_c;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit_c) begin
      out_data_r <= {6'b000000, fn_c, sl_c, pay_c, good_c, ob_c};
      out_kind_r <= kind_c;
      out_last_r <= end_c;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // A result that closes a frame leaves the frame state rearmed.
  assert property (@(posedge clk) disable iff (!rst_n)
    (step && emit_c && end_c) |=> (cnt_r == '0 && crc_r == $past(start_r)))
    else $error("frame state not rearmed after final result");

  // The CRC low byte is always followed by the CRC high byte of the same transaction.
  assert property (@(posedge clk) disable iff (!rst_n)
    (step && phase_r == rtufbc_pkg::PH_CRCL) |=> (hold_v_r && phase_r == rtufbc_pkg::PH_CRCH))
    else $error("CRC high byte did not follow CRC low byte");

  // A status result always ends the frame, and a PDU byte never does.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> ((out_kind_r == rtufbc_pkg::KIND_STATUS) ? out_last_r :
                 (out_kind_r == rtufbc_pkg::KIND_PDU) ? !out_last_r : 1'b1))
    else $error("end-of-run marking inconsistent with result kind");

  // The byte counter saturates at the frame size.
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_FRAME_BYTES))
    else $error("byte counter beyond frame size");
`endif

endmodule
